// ----- design/ps2mt_pkg.sv -----
package ps2mt_pkg;

    // field widths fixed by the packet format and the register map
    localparam int POS_WIDTH_DEF = 15;
    localparam int CFG_DATA_W    = 15;
    localparam int CFG_IDX_W     = 4;
    localparam int BYTE_W        = 8;
    localparam int BTN_W         = 3;
    localparam int DELTA_W       = 9;

    // reset values
    localparam int RESET_POS     = 320;
    localparam int RESET_X_MAX   = 639;
    localparam int RESET_Y_MAX   = 399;

    // status byte layout
    localparam int SIGN_X_BIT    = 4;
    localparam int SIGN_Y_BIT    = 5;
    localparam int OVF_X_BIT     = 6;
    localparam int OVF_Y_BIT     = 7;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_SET  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = CFG_IDX_W'(3);

    // position of the next byte within a packet
    typedef enum logic [1:0] {
        PH_STATUS = 2'd0,
        PH_DX     = 2'd1,
        PH_DY     = 2'd2
    } t_phase;

    // packet assembly state
    typedef struct packed {
        t_phase              phase;
        logic [BYTE_W-1:0]   status;
        logic [BYTE_W-1:0]   dx;
        logic [BTN_W-1:0]    buttons;
    } t_pkt_state;

endpackage

// ----- design/ps2mt_update.sv -----
module ps2mt_update #(
    parameter int POS_WIDTH = ps2mt_pkg::POS_WIDTH_DEF
) (
    input  logic                          i_req_type,
    input  logic [ps2mt_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic [POS_WIDTH-1:0]          i_set_x,
    input  logic [POS_WIDTH-1:0]          i_set_y,
    input  ps2mt_pkg::t_pkt_state         i_pkt,
    input  logic [POS_WIDTH-1:0]          i_x,
    input  logic [POS_WIDTH-1:0]          i_y,
    input  logic [POS_WIDTH-1:0]          i_x_min,
    input  logic [POS_WIDTH-1:0]          i_y_min,
    input  logic [POS_WIDTH-1:0]          i_x_max,
    input  logic [POS_WIDTH-1:0]          i_y_max,
    output ps2mt_pkg::t_pkt_state         o_pkt,
    output logic [POS_WIDTH-1:0]          o_x,
    output logic [POS_WIDTH-1:0]          o_y,
    output logic                          o_done
);
    import ps2mt_pkg::*;

    localparam int SUM_W = POS_WIDTH + 2;

    localparam logic [DELTA_W-1:0] sd256 = DELTA_W'(256);
    localparam logic [DELTA_W-1:0] sd255 = DELTA_W'(255);

    // 9-bit delta with overflow saturation
    function automatic logic signed [DELTA_W-1:0] delta_of(
        input logic sgn,
        input logic ovf,
        input logic [BYTE_W-1:0] raw
    );
        logic signed [DELTA_W-1:0] d;
        if (ovf) begin
            d = sgn ? -DELTA_W'(sd256) : DELTA_W'(sd255);
        end else begin
            d = signed'({sgn, raw});
        end
        return d;
    endfunction

    // raise to the minimum first, then lower to the maximum
    function automatic logic [POS_WIDTH-1:0] move_clamp(
        input logic [POS_WIDTH-1:0]       pos,
        input logic signed [DELTA_W-1:0]  d,
        input logic [POS_WIDTH-1:0]       lo,
        input logic [POS_WIDTH-1:0]       hi
    );
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] l;
        logic signed [SUM_W-1:0] h;
        v = signed'({2'b00, pos}) + SUM_W'(d);
        l = signed'({2'b00, lo});
        h = signed'({2'b00, hi});
        if (v < l) v = l;
        if (v > h) v = h;
        return v[POS_WIDTH-1:0];
    endfunction

    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;

    assign w_dx = delta_of(i_pkt.status[SIGN_X_BIT], i_pkt.status[OVF_X_BIT], i_pkt.dx);
    assign w_dy = delta_of(i_pkt.status[SIGN_Y_BIT], i_pkt.status[OVF_Y_BIT], i_rx_byte);

    // byte phase, held bytes, buttons and position
    always_comb begin
        o_pkt  = i_pkt;
        o_x    = i_x;
        o_y    = i_y;
        o_done = 1'b0;
        if (i_req_type == REQ_SET) begin
            o_x = i_set_x;
            o_y = i_set_y;
        end else begin
            unique case (i_pkt.phase)
                PH_DX: begin
                    o_pkt.dx    = i_rx_byte;
                    o_pkt.phase = PH_DY;
                end
                PH_DY: begin
                    o_pkt.buttons = i_pkt.status[BTN_W-1:0];
                    o_pkt.phase   = PH_STATUS;
                    o_x    = move_clamp(i_x, w_dx, i_x_min, i_x_max);
                    o_y    = move_clamp(i_y, w_dy, i_y_min, i_y_max);
                    o_done = 1'b1;
                end
                default: begin
                    // status byte, also taken for the unused phase code
                    o_pkt.status = i_rx_byte;
                    o_pkt.phase  = PH_DX;
                end
            endcase
        end
    end

endmodule

// ----- design/ps2_mouse_packet_tracker.sv -----
// ps2 mouse packet tracker
// input channel (i_in_valid / o_in_ready): one transaction per mouse byte
// or per direct position load, selected by i_req_type
// output channel (o_out_valid / i_out_ready): exactly one transaction per
// input transaction, carrying pointer position, buttons and a flag that
// is set when the byte closed a three-byte packet
// config channel (i_cfg_valid / o_cfg_ready): always ready, writes one of
// the four bounding box registers; unknown indexes are dropped
//
// an input result is registered in the result register, or first in the
// skid register while that is held; throughput: one transaction per cycle
// unless the skid register is full, set by the combinational delta add/clamp
//
// the output side has a result register plus a skid register, so one more
// transaction is taken while a result waits; o_in_ready falls only when
// both hold results that the receiver has not taken
//
// reset (synchronous, active low) empties the output stage, restarts
// packet framing at the status byte, puts the pointer at 320,320 and loads
// the default box 0..639 by 0..399
module ps2_mouse_packet_tracker #(
    parameter int POS_WIDTH = ps2mt_pkg::POS_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input transactions
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_req_type,
    input  logic [ps2mt_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic [POS_WIDTH-1:0]              i_set_x,
    input  logic [POS_WIDTH-1:0]              i_set_y,
    // result transactions
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [POS_WIDTH-1:0]              o_pos_x,
    output logic [POS_WIDTH-1:0]              o_pos_y,
    output logic [ps2mt_pkg::BTN_W-1:0]       o_button_bits,
    output logic                              o_packet_done,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ps2mt_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ps2mt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ps2mt_pkg::*;

    // bounding box registers
    logic [POS_WIDTH-1:0] r_x_min, r_y_min, r_x_max, r_y_max;

    // tracker state
    t_pkt_state           r_pkt, n_pkt;
    logic [POS_WIDTH-1:0] r_x, r_y, n_x, n_y;
    logic                 n_done;

    // output stage: result register and skid register
    logic                 r_out_valid, n_out_valid;
    logic                 r_skid_valid, n_skid_valid;
    logic [POS_WIDTH-1:0] r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic [BTN_W-1:0]     r_out_btn, r_skid_btn;
    logic                 r_out_done, r_skid_done;

    logic w_in_acc, w_out_acc, w_cfg_acc, w_main_free;
    logic w_load_new, w_load_skid, w_fill_skid;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid & o_cfg_ready;

    // the skid register being full is the only back-pressure
    assign o_in_ready  = ~r_skid_valid;
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_out_acc   = r_out_valid & i_out_ready;

    ps2mt_update #(
        .POS_WIDTH (POS_WIDTH)
    ) u_update (
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_set_x    (i_set_x),
        .i_set_y    (i_set_y),
        .i_pkt      (r_pkt),
        .i_x        (r_x),
        .i_y        (r_y),
        .i_x_min    (r_x_min),
        .i_y_min    (r_y_min),
        .i_x_max    (r_x_max),
        .i_y_max    (r_y_max),
        .o_pkt      (n_pkt),
        .o_x        (n_x),
        .o_y        (n_y),
        .o_done     (n_done)
    );

    // register writes, upper data bits dropped when positions are narrower
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_y_min <= '0;
            r_x_max <= POS_WIDTH'(RESET_X_MAX);
            r_y_max <= POS_WIDTH'(RESET_Y_MAX);
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_X_MIN: r_x_min <= i_cfg_data[POS_WIDTH-1:0];
                CFG_Y_MIN: r_y_min <= i_cfg_data[POS_WIDTH-1:0];
                CFG_X_MAX: r_x_max <= i_cfg_data[POS_WIDTH-1:0];
                CFG_Y_MAX: r_y_max <= i_cfg_data[POS_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // tracker state moves on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '{phase: PH_STATUS, status: '0, dx: '0, buttons: '0};
            r_x   <= POS_WIDTH'(RESET_POS);
            r_y   <= POS_WIDTH'(RESET_POS);
        end else if (w_in_acc) begin
            r_pkt <= n_pkt;
            r_x   <= n_x;
            r_y   <= n_y;
        end
    end

    // output stage steering
    assign w_main_free = ~r_out_valid | w_out_acc;
    assign w_load_skid = w_main_free & r_skid_valid;
    assign w_load_new  = w_main_free & ~r_skid_valid & w_in_acc;
    assign w_fill_skid = ~w_main_free & w_in_acc;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_main_free) begin
            n_out_valid = r_skid_valid | w_in_acc;
        end
        if (w_load_skid) begin
            n_skid_valid = 1'b0;
        end else if (w_fill_skid) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_load_skid) begin
            r_out_x    <= r_skid_x;
            r_out_y    <= r_skid_y;
            r_out_btn  <= r_skid_btn;
            r_out_done <= r_skid_done;
        end else if (w_load_new) begin
            r_out_x    <= n_x;
            r_out_y    <= n_y;
            r_out_btn  <= n_pkt.buttons;
            r_out_done <= n_done;
        end
        if (w_fill_skid) begin
            r_skid_x    <= n_x;
            r_skid_y    <= n_y;
            r_skid_btn  <= n_pkt.buttons;
            r_skid_done <= n_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pos_x       = r_out_x;
    assign o_pos_y       = r_out_y;
    assign o_button_bits = r_out_btn;
    assign o_packet_done = r_out_done;

    // skid register never holds a result ahead of an empty result register
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while result register empty");

    // back-pressure only when a result is waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result pending");

    // a direct load lands in the position registers unchanged
    a_set_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_req_type == REQ_SET) |=> (r_x == $past(i_set_x) && r_y == $past(i_set_y)))
        else $error("direct position load not taken");

    // a completed packet leaves x inside a proper box
    a_clamp_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_done && r_x_min <= r_x_max) |-> (n_x >= r_x_min && n_x <= r_x_max))
        else $error("pointer x outside bounding box");

    // a completed packet leaves y inside a proper box
    a_clamp_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_done && r_y_min <= r_y_max) |-> (n_y >= r_y_min && n_y <= r_y_max))
        else $error("pointer y outside bounding box");

endmodule
